[rtl/phdlc_pkg.sv]
// shared types, constants and fcs-16 update for the ppp hdlc receive deframer
package phdlc_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7e;
    localparam logic [7:0]  ESC_BYTE  = 8'h7d;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [7:0]  ADDR_BYTE = 8'hff;
    localparam logic [7:0]  CTRL_BYTE = 8'h03;
    localparam logic [15:0] FCS_INIT  = 16'hffff;
    localparam logic [15:0] FCS_GOOD  = 16'hf0b8;
    localparam logic [15:0] FCS_POLY  = 16'h8408;
    localparam logic [15:0] COUNT_MAX = 16'hffff;

    localparam logic [15:0] MAX_LEN_RESET = 16'd1500;

    localparam logic REG_ESCAPE_ENABLE = 1'b0;
    localparam logic REG_MAX_FRAME_LEN = 1'b1;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_BAD_FCS  = 2'd1;
    localparam logic [1:0] STATUS_BAD_HDR  = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_last;
        logic [1:0]  frame_status;
        logic [15:0] frame_length;
    } result_t;

    function automatic logic [15:0] fcs16_update(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] c;
        c = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/phdlc_in_reg.sv]
// input register stage holding one received byte
module phdlc_in_reg
    import phdlc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

[rtl/phdlc_core.sv]
// frame state, unstuffing, fcs check and configuration registers
module phdlc_core
    import phdlc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        out_space,
    output logic        advance,
    output logic        res_valid,
    output result_t     res
);

    logic        esc_en_reg;
    logic [15:0] max_len_reg;

    logic        in_frame_reg, in_frame_next;
    logic        esc_reg, esc_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] fcs_reg, fcs_next;
    logic        hdr_ok_reg, hdr_ok_next;

    logic [7:0]  data;
    logic [15:0] idx;
    logic [15:0] close_len;

    assign advance   = in_valid && out_space;
    assign data      = esc_reg ? (in_byte ^ ESC_XOR) : in_byte;
    assign idx       = count_reg - 16'd1;
    assign close_len = count_reg - 16'd1;

    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        fcs_next      = fcs_reg;
        hdr_ok_next   = hdr_ok_reg;
        res_valid     = 1'b0;
        res           = '0;
        if (!in_frame_reg) begin
            if (in_byte == FLAG_BYTE) begin
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                count_next    = 16'd1;
                fcs_next      = FCS_INIT;
                hdr_ok_next   = 1'b1;
            end
        end else if (in_byte == FLAG_BYTE) begin
            in_frame_next    = 1'b0;
            esc_next         = 1'b0;
            res_valid        = 1'b1;
            res.is_last      = 1'b1;
            res.frame_length = close_len;
            if (fcs_reg != FCS_GOOD) begin
                res.frame_status = STATUS_BAD_FCS;
            end else if (!hdr_ok_reg || close_len < 16'd2) begin
                res.frame_status = STATUS_BAD_HDR;
            end else begin
                res.frame_status = STATUS_GOOD;
            end
        end else if (esc_en_reg && in_byte == ESC_BYTE) begin
            esc_next = 1'b1;
        end else begin
            esc_next = 1'b0;
            if ((idx == 16'd0 && data != ADDR_BYTE) || (idx == 16'd1 && data != CTRL_BYTE)) begin
                hdr_ok_next = 1'b0;
            end
            fcs_next   = fcs16_update(fcs_reg, data);
            count_next = (count_reg < COUNT_MAX) ? count_reg + 16'd1 : count_reg;
            res_valid  = 1'b1;
            if (count_next >= max_len_reg) begin
                in_frame_next    = 1'b0;
                res.is_last      = 1'b1;
                res.frame_status = STATUS_OVERFLOW;
                res.frame_length = count_next - 16'd1;
            end else begin
                res.data_byte = data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_en_reg   <= 1'b1;
            max_len_reg  <= MAX_LEN_RESET;
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            count_reg    <= 16'd0;
            fcs_reg      <= FCS_INIT;
            hdr_ok_reg   <= 1'b1;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ESCAPE_ENABLE: esc_en_reg  <= cfg_data[0];
                    REG_MAX_FRAME_LEN: max_len_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (advance) begin
                in_frame_reg <= in_frame_next;
                esc_reg      <= esc_next;
                count_reg    <= count_next;
                fcs_reg      <= fcs_next;
                hdr_ok_reg   <= hdr_ok_next;
            end
        end
    end

endmodule

[rtl/phdlc_out_reg.sv]
// result register driving the output channel
module phdlc_out_reg
    import phdlc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     res,
    output logic        out_space,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_byte,
    output logic        m_is_last,
    output logic [1:0]  m_frame_status,
    output logic [15:0] m_frame_length
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign out_space  = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_data_byte    = res_reg.data_byte;
    assign m_is_last      = res_reg.is_last;
    assign m_frame_status = res_reg.frame_status;
    assign m_frame_length = res_reg.frame_length;

endmodule

[rtl/ppp_hdlc_receive_deframer_core.sv]
// ppp hdlc-like receive deframer top level
// input channel s_*: one received serial byte per transaction
// output channel m_*: one unstuffed data byte per transaction, or a frame end
//   transaction (m_is_last high) carrying frame_status and frame_length
// opening flags, escape bytes and bytes outside a frame give no transaction
// configuration: cfg_we writes cfg_data into register cfg_index (0 escape
//   enable, 1 max frame length); user must write only while idle (unchecked)
// path: an accepted byte enters the input register, then the frame logic with
//   fcs-16 loads its result into the result register
// throughput: one byte per cycle unless m_ready stalls the output, with the
//   fcs-16 and frame state updates combinational between the registers
// stall: with the result register full and m_ready low, one more byte is
//   held in the input register before s_ready drops
// reset: aresetn low clears both registers, leaves the receiver waiting for
//   an opening flag, and restores escape enable 1 and max length 1500
module ppp_hdlc_receive_deframer_core
    import phdlc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_byte,
    output logic        m_is_last,
    output logic [1:0]  m_frame_status,
    output logic [15:0] m_frame_length
);

    logic       advance;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_space;
    logic       res_valid;
    result_t    res;

    phdlc_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    phdlc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .out_space (out_space),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    phdlc_out_reg u_out_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (advance && res_valid),
        .res            (res),
        .out_space      (out_space),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_byte    (m_data_byte),
        .m_is_last      (m_is_last),
        .m_frame_status (m_frame_status),
        .m_frame_length (m_frame_length)
    );

    a_last_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_last |-> m_data_byte == 8'h00)
        else $error("frame end transaction carries a data byte");

    a_data_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_last |-> m_frame_status == STATUS_GOOD && m_frame_length == 16'd0)
        else $error("data transaction carries status or length");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid && m_valid && !m_ready)
        else $error("input stalled while a stage was free");

    a_advance_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> in_valid && out_space)
        else $error("frame logic advanced without an item or output space");

endmodule
